FILE: hw/rtl/iirdf_pkg.sv
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared types, constants and helpers for the third-order direct-form-I
// IIR filter.
// ----------------------------------------------------------------------------
package iirdf_pkg;

  localparam int DATA_W         = 16;
  localparam int COEF_W         = 16;
  localparam int TAPS           = 4;
  localparam int COEF_FRAC_BITS = 12;
  localparam int HIST_DEPTH     = 3;
  localparam int NUM_REGS       = 7;

  localparam int NUM_TERMS = 2 * TAPS - 1;
  localparam int CNT_W     = $clog2(NUM_TERMS + 2);
  localparam int LAST_CNT  = NUM_TERMS + 1;

  // one ring per history, one spare slot for the entry being written
  localparam int RING_W    = $clog2(HIST_DEPTH + 1);
  localparam int MEM_AW    = RING_W + 1;
  localparam int MEM_DEPTH = 2 ** MEM_AW;

  localparam int PROD_W = DATA_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(NUM_TERMS + 1) + 1;

  localparam int REG_AW  = $clog2(NUM_REGS);
  localparam int PADDR_W = REG_AW + 2;
  localparam int PDATA_W = 32;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic HIST_X = 1'b0;
  localparam logic HIST_Y = 1'b1;

  typedef enum logic [REG_AW-1:0] {
    REG_FF_COEF_0 = 3'd0,
    REG_FF_COEF_1 = 3'd1,
    REG_FF_COEF_2 = 3'd2,
    REG_FF_COEF_3 = 3'd3,
    REG_FB_COEF_1 = 3'd4,
    REG_FB_COEF_2 = 3'd5,
    REG_FB_COEF_3 = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic init;
    logic mul_en;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

  function automatic logic [COEF_W-1:0] coef_reset(input int idx);
    logic [COEF_W-1:0] v;
    v = '0;
    if (idx == int'(REG_FF_COEF_0)) begin
      v = COEF_W'(1) << COEF_FRAC_BITS;
    end
    return v;
  endfunction

  // term 0..TAPS-1 are feed-forward, the rest feedback
  function automatic logic [REG_AW-1:0] term_reg(input logic [CNT_W-1:0] t);
    int v;
    if (int'(t) < TAPS) begin
      v = int'(t);
    end else begin
      v = int'(t) - TAPS + int'(REG_FB_COEF_1);
    end
    return REG_AW'(v);
  endfunction

endpackage

FILE: hw/rtl/iirdf_mac.sv
// ----------------------------------------------------------------------------
// iirdf_mac
// Shared multiply-accumulate unit: registered product, accumulator with
// rounding bias preload, and a round/saturate stage on the output.
// ----------------------------------------------------------------------------
module iirdf_mac (
  input  logic                                 clk,
  input  iirdf_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [iirdf_pkg::COEF_W-1:0]  coef,
  input  logic signed [iirdf_pkg::DATA_W-1:0]  operand,
  output logic signed [iirdf_pkg::DATA_W-1:0]  result
);
  import iirdf_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  q;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * operand;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      acc_r <= $signed(ROUND_BIAS);
    end else if (ctrl.acc_en) begin
      if (ctrl.sub) begin
        acc_r <= acc_r - ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  always_comb begin
    q = acc_r >>> COEF_FRAC_BITS;
    if (q > SAT_MAX) begin
      result = SAT_MAX[DATA_W-1:0];
    end else if (q < SAT_MIN) begin
      result = SAT_MIN[DATA_W-1:0];
    end else begin
      result = q[DATA_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/iir_filter_direct_form.sv
// ----------------------------------------------------------------------------
// iir_filter_direct_form
// Third-order direct-form-I IIR filter, Q4.12 coefficients, 16-bit samples.
// ----------------------------------------------------------------------------
// One sample is processed at a time, and a new sample is accepted only once
// the previous one is done: the seven products go one per cycle through a single
// shared 16x16 multiplier, fed from the history RAM (registered read),
// followed by the round/saturate in the finish state. A stalled result holds
// the block in its finish state until the output is taken. Both histories live
// in a small ring RAM; restart or reset invalidates every entry at once.
module iir_filter_direct_form (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [iirdf_pkg::DATA_W-1:0]   in_sample,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [iirdf_pkg::DATA_W-1:0]   out_filtered,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [iirdf_pkg::PADDR_W-1:0]         paddr,
  input  logic [iirdf_pkg::PDATA_W-1:0]         pwdata,
  output logic [iirdf_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready
);
  import iirdf_pkg::*;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [RING_W-1:0]         ptr_r;
  logic signed [DATA_W-1:0]  sample_r;
  logic [COEF_W-1:0]         coef_r [NUM_REGS];

  logic [DATA_W-1:0]         hist_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]      vld_r;
  logic [DATA_W-1:0]         rd_data_r;
  logic                      rd_vld_r;
  logic                      rd_en;
  logic [MEM_AW-1:0]         rd_addr;
  logic                      wr_en;
  logic [MEM_AW-1:0]         wr_addr;
  logic [DATA_W-1:0]         wr_data;

  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_filtered_r;

  logic                      in_accept;
  logic                      out_free;
  logic                      fin_go;
  logic [CNT_W-1:0]          term_mul;
  logic [CNT_W-1:0]          term_acc;
  logic [CNT_W-1:0]          rd_off;
  logic                      rd_is_ff;

  mac_ctrl_t                 mac_ctrl;
  logic signed [COEF_W-1:0]  mac_coef;
  logic signed [DATA_W-1:0]  mac_operand;
  logic signed [DATA_W-1:0]  mac_result;

  logic [REG_AW-1:0]         reg_idx;
  logic                      reg_ok;
  logic                      cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_ok  = int'(reg_idx) < NUM_REGS;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_ok ? PDATA_W'(coef_r[reg_idx]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= coef_reset(i);
      end
    end else if (cfg_wr && reg_ok) begin
      coef_r[reg_idx] <= pwdata[COEF_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_stall     = (state_r != ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign fin_go       = (state_r == ST_FINISH) && out_free;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LAST_CNT)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign term_mul = cnt_r - CNT_W'(1);
  assign term_acc = cnt_r - CNT_W'(2);
  assign rd_is_ff = int'(cnt_r) < TAPS;
  assign rd_off   = rd_is_ff ? cnt_r : cnt_r - CNT_W'(TAPS - 1);

  always_comb begin
    mac_ctrl = '0;
    rd_en    = 1'b0;
    rd_addr  = {rd_is_ff ? HIST_X : HIST_Y, ptr_r - rd_off[RING_W-1:0]};
    wr_en    = 1'b0;
    wr_addr  = {HIST_X, ptr_r};
    wr_data  = sample_r;
    unique case (state_r)
      ST_IDLE: begin
        mac_ctrl.init = in_accept;
      end
      ST_RUN: begin
        wr_en           = (cnt_r == '0);
        rd_en           = (cnt_r >= CNT_W'(1)) && (cnt_r < CNT_W'(NUM_TERMS));
        mac_ctrl.mul_en = (cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(NUM_TERMS));
        mac_ctrl.acc_en = (cnt_r >= CNT_W'(2));
        mac_ctrl.sub    = (int'(term_acc) >= TAPS);
      end
      ST_FINISH: begin
        wr_en   = out_free;
        wr_addr = {HIST_Y, ptr_r};
        wr_data = mac_result;
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin_go) begin
        ptr_r <= ptr_r + RING_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_sample;
    end
  end

  // --------------------------------------------------------------------------
  // History RAM
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (in_accept && in_restart) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // MAC
  // --------------------------------------------------------------------------
  assign mac_coef    = $signed(coef_r[term_reg(term_mul)]);
  assign mac_operand = (term_mul == '0) ? sample_r :
                       (rd_vld_r ? $signed(rd_data_r) : '0);

  iirdf_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .coef    (mac_coef),
    .operand (mac_operand),
    .result  (mac_result)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_filtered_r <= mac_result;
    end
  end

endmodule

FILE: dv/tb_iir_filter_direct_form.sv
// ----------------------------------------------------------------------------
// tb_iir_filter_direct_form
// Self-checking bench for the third-order direct-form-I IIR filter. A queue-fed
// driver pushes samples and the monitor checks each filtered output against an
// in-bench fixed-point filter. The run covers directed corner cases, then
// random runs of samples under several coefficient sets and stall patterns.
// ----------------------------------------------------------------------------
module tb_iir_filter_direct_form;
  import iirdf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 200;
  localparam int MAX_REPORTS    = 10;
  localparam int UNUSED_REG     = NUM_REGS;

  typedef struct {
    logic signed [DATA_W-1:0] sample;
    logic                     restart;
  } sample_txn_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [DATA_W-1:0]  in_sample = '0;
  logic                      in_restart = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [DATA_W-1:0]  out_filtered;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // filter state of the bench
  logic signed [COEF_W-1:0]  coef_model [NUM_REGS];
  logic signed [DATA_W-1:0]  x_hist [HIST_DEPTH];
  logic signed [DATA_W-1:0]  y_hist [HIST_DEPTH];

  sample_txn_t               sample_q [$];
  logic signed [DATA_W-1:0]  filtered_q [$];

  int send_idle_pct = 35;
  int recv_idle_pct = 75;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int n_queued      = 0;
  int n_accepted    = 0;
  int n_results     = 0;
  int n_cfg_writes  = 0;
  int n_coef_sets   = 0;
  int n_restarts    = 0;
  int n_clipped     = 0;
  int n_errors      = 0;

  iir_filter_direct_form DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_history();
    for (int i = 0; i < HIST_DEPTH; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] iir_predict(
    input logic signed [DATA_W-1:0] x,
    input logic                     restart
  );
    longint acc;
    longint q;
    logic signed [DATA_W-1:0] y;
    if (restart) begin
      clear_history();
    end
    acc = longint'(coef_model[int'(REG_FF_COEF_0)]) * longint'(x);
    for (int j = 1; j < TAPS; j++) begin
      acc += longint'(coef_model[int'(REG_FF_COEF_0) + j]) * longint'(x_hist[j-1]);
      acc -= longint'(coef_model[int'(REG_FB_COEF_1) + j - 1]) * longint'(y_hist[j-1]);
    end
    acc += longint'(1) << (COEF_FRAC_BITS - 1);
    q = acc >>> COEF_FRAC_BITS;
    if (q > 32767) begin
      q = 32767;
      n_clipped++;
    end else if (q < -32768) begin
      q = -32768;
      n_clipped++;
    end
    y = DATA_W'(q);
    for (int j = HIST_DEPTH - 1; j > 0; j--) begin
      x_hist[j] = x_hist[j-1];
      y_hist[j] = y_hist[j-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    return y;
  endfunction

  // driver
  always @(posedge clk) begin : drive_samples
    sample_txn_t txn;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        filtered_q.insert(filtered_q.size(), iir_predict(in_sample, in_restart));
        if (in_restart) begin
          n_restarts++;
        end
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          txn = sample_q.pop_front();
          in_valid   <= 1'b1;
          in_sample  <= txn.sample;
          in_restart <= txn.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin : check_filtered
    logic signed [DATA_W-1:0] want;
    logic stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (filtered_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("ERROR: unexpected output %0d", out_filtered);
          end
        end else begin
          want = filtered_q.pop_front();
          if (out_filtered !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("ERROR: output %0d: filtered expected %0d, got %0d",
                       n_results, want, out_filtered);
            end
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= LONG_HOLD;
        stall_next = 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(99) < recv_idle_pct);
      end
      out_stall <= stall_next;
    end
  end

  // watchdog: cycles without any transaction
  initial begin : watchdog
    int quiet;
    int last_activity;
    int activity;
    quiet = 0;
    last_activity = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      activity = n_accepted + n_results + n_cfg_writes;
      if (activity != last_activity || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      last_activity = activity;
    end
    $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_iir_filter_direct_form: FAIL");
    $finish;
  end

  task automatic cfg_write(input int idx, input logic signed [COEF_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= {{(PDATA_W-COEF_W){value[COEF_W-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx < NUM_REGS) begin
      coef_model[idx] = value;
    end
    n_cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_coefs(
    input logic signed [COEF_W-1:0] b0, input logic signed [COEF_W-1:0] b1,
    input logic signed [COEF_W-1:0] b2, input logic signed [COEF_W-1:0] b3,
    input logic signed [COEF_W-1:0] a1, input logic signed [COEF_W-1:0] a2,
    input logic signed [COEF_W-1:0] a3
  );
    cfg_write(int'(REG_FF_COEF_0), b0);
    cfg_write(int'(REG_FF_COEF_1), b1);
    cfg_write(int'(REG_FF_COEF_2), b2);
    cfg_write(int'(REG_FF_COEF_3), b3);
    cfg_write(int'(REG_FB_COEF_1), a1);
    cfg_write(int'(REG_FB_COEF_2), a2);
    cfg_write(int'(REG_FB_COEF_3), a3);
    n_coef_sets++;
  endtask

  task automatic push_sample(input logic signed [DATA_W-1:0] s, input logic r);
    sample_txn_t txn;
    txn.sample  = s;
    txn.restart = r;
    sample_q.insert(sample_q.size(), txn);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || filtered_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef(input int span);
    return COEF_W'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_sample();
    logic signed [DATA_W-1:0] s;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2: s = 16'sh0000;
          default: s = 16'shFFFF;
        endcase
      end
      1, 2, 3: s = rand_coef(64);
      default: s = DATA_W'($urandom);
    endcase
    return s;
  endfunction

  // runs of samples, mostly opened by a restart, with a few stray restarts
  task automatic queue_runs(input int n_items);
    int len;
    int done;
    done = 0;
    while (done < n_items) begin
      len = $urandom_range(40, 5);
      for (int i = 0; i < len; i++) begin
        push_sample(rand_sample(),
                    (i == 0 && $urandom_range(9) < 7) || ($urandom_range(99) < 3));
      end
      done += len;
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_REGS; i++) begin
      coef_model[i] = '0;
    end
    coef_model[int'(REG_FF_COEF_0)] = 16'sd4096;
    clear_history();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // unity gain after reset, start-up from zero history
    push_sample(16'sd0, 1'b1);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b0);
    wait_drained();

    // half gain: exact halves round up
    set_coefs(16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sd1, 1'b1);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd3, 1'b0);
    push_sample(-16'sd3, 1'b0);
    wait_drained();

    // max gain: clipping both ways
    set_coefs(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    push_sample(16'sd32767, 1'b0);
    push_sample(-16'sd32768, 1'b0);
    wait_drained();

    // integrator: output is fed back; restart mid-stream
    set_coefs(16'sd4096, 16'sd0, 16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0);
    cfg_write(UNUSED_REG, 16'sh7FFF);
    push_sample(16'sd1000, 1'b1);
    push_sample(16'sd1000, 1'b0);
    push_sample(16'sd30000, 1'b0);
    push_sample(16'sd5, 1'b0);
    push_sample(16'sd7, 1'b1);
    push_sample(-16'sd20000, 1'b0);
    wait_drained();

    // mild random filter; receiver mostly stalled, one long hold-off
    set_coefs(rand_coef(4096), rand_coef(4096), rand_coef(4096), rand_coef(4096),
              rand_coef(2048), rand_coef(1024), rand_coef(512));
    send_idle_pct = 35;
    recv_idle_pct = 75;
    hold_req = hold_req + 1;
    queue_runs(PHASE_ITEMS);
    wait_drained();

    // coefficient extremes, heavy clipping
    set_coefs(16'sd32767, -16'sd32768, rand_coef(32767), 16'sd32767,
              -16'sd32768, 16'sd32767, rand_coef(32767));
    cfg_write(UNUSED_REG, -16'sd32768);
    send_idle_pct = 75;
    recv_idle_pct = 35;
    queue_runs(PHASE_ITEMS);
    wait_drained();

    // full-range random coefficients, no idling
    set_coefs(rand_coef(32767), rand_coef(32767), rand_coef(32767), rand_coef(32767),
              rand_coef(32767), rand_coef(32767), rand_coef(32767));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_runs(PHASE_ITEMS);
    wait_drained();

    repeat (30) @(posedge clk);
    $display("Filtered %0d samples under %0d coefficient sets: %0d restarts, %0d clipped.",
             n_accepted, n_coef_sets, n_restarts, n_clipped);
    $display("Mismatches: %0d, outputs still pending: %0d", n_errors, filtered_q.size());
    if (n_errors == 0 && filtered_q.size() == 0) begin
      $display("tb_iir_filter_direct_form: PASS");
    end else begin
      $display("tb_iir_filter_direct_form: FAIL");
    end
    $finish;
  end

endmodule
